>>> rtl/cit_pkg.sv
// Shared types and constants for the three-channel interval timer.
// No dependencies.
package cit_pkg;

  localparam int NCHAN      = 3;
  localparam int CHAN_W     = 2;
  localparam int PRESCALE_W = 4;
  localparam int COUNT_W    = 16;
  localparam int CTRL_W     = 6;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_IDLE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LOW   = 2'd1,
    ACC_HIGH  = 2'd2,
    ACC_WORD  = 2'd3
  } access_t;

  // Control word mode field codes that are supported.
  localparam logic [2:0] MODE_INT    = 3'd0;
  localparam logic [2:0] MODE_RATE   = 3'd2;
  localparam logic [2:0] MODE_SQUARE = 3'd3;

  // Port offset of the control word port; same code in the channel-select field
  // of a control word means readback.
  localparam logic [CHAN_W-1:0] CTRL_PORT = 2'd3;

  localparam logic [7:0]         CTRL_READ_VALUE = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_WRAP      = 16'hFFFF;

endpackage

>>> rtl/three_channel_interval_timer.sv
// Three-channel 16-bit interval timer, top level.
// Depends on cit_pkg.
//
// Usage: every input beat is a bus tick, a port write, a port read or an idle
// beat, and each one returns exactly one result beat. The block takes one beat
// per clock cycle while the input is not stalled. A beat passes through the
// input register, then a single processing stage that updates the prescaler
// and all three channels in parallel and loads the result register. The result
// register sits between the two sides, so a new beat is taken while an older
// result waits; input stall rises only when both registers are full and the
// output side stalls. The prescaler divides ticks by PRESCALE_DIVIDE (1..15).
module three_channel_interval_timer #(
  parameter int PRESCALE_DIVIDE = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [1:0] in_port_offset,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic [2:0] out_channel_expired,
  output logic       out_command_error
);

  localparam logic [cit_pkg::PRESCALE_W-1:0] PRESCALE_LIMIT =
    cit_pkg::PRESCALE_W'(PRESCALE_DIVIDE);

  // input register
  logic                        s1_valid_r;
  cit_pkg::op_t                s1_op_r;
  logic [cit_pkg::CHAN_W-1:0]  s1_port_r;
  logic [7:0]                  s1_data_r;

  // result register
  logic                        out_valid_r;
  logic [7:0]                  out_read_data_r;
  logic [cit_pkg::NCHAN-1:0]   out_expired_r;
  logic                        out_error_r;

  // timer state
  logic [cit_pkg::PRESCALE_W-1:0] prescale_r, prescale_nxt;
  logic [cit_pkg::CTRL_W-1:0]     cw_r      [cit_pkg::NCHAN];
  logic [cit_pkg::CTRL_W-1:0]     cw_nxt    [cit_pkg::NCHAN];
  logic [cit_pkg::COUNT_W-1:0]    init_r    [cit_pkg::NCHAN];
  logic [cit_pkg::COUNT_W-1:0]    init_nxt  [cit_pkg::NCHAN];
  logic [cit_pkg::COUNT_W-1:0]    cur_r     [cit_pkg::NCHAN];
  logic [cit_pkg::COUNT_W-1:0]    cur_nxt   [cit_pkg::NCHAN];
  logic [cit_pkg::COUNT_W-1:0]    latch_r   [cit_pkg::NCHAN];
  logic [cit_pkg::COUNT_W-1:0]    latch_nxt [cit_pkg::NCHAN];
  logic [cit_pkg::NCHAN-1:0]      running_r, running_nxt;
  logic [cit_pkg::NCHAN-1:0]      reload_r, reload_nxt;
  logic [cit_pkg::NCHAN-1:0]      hbn_r, hbn_nxt;

  logic                           fire;
  logic [7:0]                     rd_nxt;
  logic [cit_pkg::NCHAN-1:0]      exp_nxt;
  logic                           err_nxt;

  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !fire;

  always_comb begin
    logic [cit_pkg::PRESCALE_W-1:0] inc;
    logic                           tick_edge;
    logic [cit_pkg::COUNT_W-1:0]    cnt;
    logic [cit_pkg::COUNT_W-1:0]    dec;
    logic [cit_pkg::CHAN_W-1:0]     sel;
    cit_pkg::access_t               acc;
    logic [2:0]                     mode;
    logic                           start;

    prescale_nxt = prescale_r;
    cw_nxt       = cw_r;
    init_nxt     = init_r;
    cur_nxt      = cur_r;
    latch_nxt    = latch_r;
    running_nxt  = running_r;
    reload_nxt   = reload_r;
    hbn_nxt      = hbn_r;
    rd_nxt       = 8'h00;
    exp_nxt      = '0;
    err_nxt      = 1'b0;

    inc       = prescale_r + 1'b1;
    tick_edge = (inc >= PRESCALE_LIMIT);
    cnt       = '0;
    dec       = '0;
    start     = 1'b0;
    sel       = s1_data_r[7:6];
    acc       = cit_pkg::access_t'(s1_data_r[5:4]);
    mode      = s1_data_r[3:1];

    if (fire) begin
      case (s1_op_r)
        cit_pkg::OP_TICK: begin
          prescale_nxt = tick_edge ? '0 : inc;
          for (int ch = 0; ch < cit_pkg::NCHAN; ch++) begin
            if (tick_edge && running_r[ch]) begin
              cnt = reload_r[ch] ? init_r[ch] : cur_r[ch];
              reload_nxt[ch] = 1'b0;
              if (cnt == '0) begin
                cur_nxt[ch] = cit_pkg::COUNT_WRAP;
              end else begin
                dec = cnt - 1'b1;
                cur_nxt[ch] = dec;
                if (dec == '0) begin
                  exp_nxt[ch] = 1'b1;
                  if (cw_r[ch][3:1] == cit_pkg::MODE_INT) begin
                    running_nxt[ch] = 1'b0;
                  end else begin
                    reload_nxt[ch] = 1'b1;
                  end
                end
              end
            end
          end
        end
        cit_pkg::OP_WRITE: begin
          if (s1_port_r == cit_pkg::CTRL_PORT) begin
            if (sel == cit_pkg::CTRL_PORT) begin
              err_nxt = 1'b1;  // readback
            end else if (acc == cit_pkg::ACC_LATCH) begin
              for (int ch = 0; ch < cit_pkg::NCHAN; ch++) begin
                if (sel == cit_pkg::CHAN_W'(ch)) latch_nxt[ch] = cur_r[ch];
              end
            end else if (!(mode inside {cit_pkg::MODE_INT, cit_pkg::MODE_RATE,
                                        cit_pkg::MODE_SQUARE}) || s1_data_r[0]) begin
              err_nxt = 1'b1;  // unsupported mode or BCD
            end else begin
              for (int ch = 0; ch < cit_pkg::NCHAN; ch++) begin
                if (sel == cit_pkg::CHAN_W'(ch)) begin
                  cw_nxt[ch]  = s1_data_r[5:0];
                  hbn_nxt[ch] = 1'b0;
                end
              end
            end
          end else begin
            for (int ch = 0; ch < cit_pkg::NCHAN; ch++) begin
              if (s1_port_r == cit_pkg::CHAN_W'(ch)) begin
                start = 1'b1;
                case (cit_pkg::access_t'(cw_r[ch][5:4]))
                  cit_pkg::ACC_LOW:  init_nxt[ch] = {8'h00, s1_data_r};
                  cit_pkg::ACC_HIGH: init_nxt[ch] = {s1_data_r, 8'h00};
                  cit_pkg::ACC_WORD: begin
                    if (hbn_r[ch]) begin
                      init_nxt[ch] = {s1_data_r, init_r[ch][7:0]};
                    end else begin
                      init_nxt[ch] = {init_r[ch][15:8], s1_data_r};
                      start = 1'b0;  // low byte alone does not start
                    end
                    hbn_nxt[ch] = !hbn_r[ch];
                  end
                  default: ;
                endcase
                if (start) begin
                  running_nxt[ch] = 1'b1;
                  reload_nxt[ch]  = 1'b1;
                end
              end
            end
          end
        end
        cit_pkg::OP_READ: begin
          if (s1_port_r == cit_pkg::CTRL_PORT) begin
            rd_nxt = cit_pkg::CTRL_READ_VALUE;
          end else begin
            for (int ch = 0; ch < cit_pkg::NCHAN; ch++) begin
              if (s1_port_r == cit_pkg::CHAN_W'(ch)) begin
                rd_nxt        = latch_r[ch][7:0];
                latch_nxt[ch] = {8'h00, latch_r[ch][15:8]};
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prescale_r  <= '0;
      running_r   <= '0;
      reload_r    <= '0;
      hbn_r       <= '0;
      for (int ch = 0; ch < cit_pkg::NCHAN; ch++) begin
        cw_r[ch]    <= '0;
        init_r[ch]  <= '0;
        cur_r[ch]   <= '0;
        latch_r[ch] <= '0;
      end
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      prescale_r <= prescale_nxt;
      running_r  <= running_nxt;
      reload_r   <= reload_nxt;
      hbn_r      <= hbn_nxt;
      cw_r       <= cw_nxt;
      init_r     <= init_nxt;
      cur_r      <= cur_nxt;
      latch_r    <= latch_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_op_r   <= cit_pkg::op_t'(in_operation);
      s1_port_r <= in_port_offset;
      s1_data_r <= in_write_data;
    end
    if (fire) begin
      out_read_data_r <= rd_nxt;
      out_expired_r   <= exp_nxt;
      out_error_r     <= err_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_read_data_r;
  assign out_channel_expired = out_expired_r;
  assign out_command_error   = out_error_r;

`ifndef NO_ASSERTIONS
  a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
    prescale_r < PRESCALE_LIMIT)
    else $error("prescaler out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipe");

  a_expiry_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && exp_nxt != '0) |-> (s1_op_r == cit_pkg::OP_TICK && prescale_nxt == '0))
    else $error("expiry without a prescaled tick");

  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_expired_r == '0 && out_read_data_r == 8'h00))
    else $error("command error beat carries other results");

  a_mode0_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && exp_nxt[0] && cw_r[0][3:1] == cit_pkg::MODE_INT) |=> !running_r[0])
    else $error("mode 0 channel kept running after expiry");
`endif

endmodule
